/* rtl/encoder_frame_check_position_filter_top_assert.svh */
// Assertion macros shared by the frame check and position filter checkers.
`ifndef ENCODER_FRAME_CHECK_POSITION_FILTER_TOP_ASSERT_SVH
`define ENCODER_FRAME_CHECK_POSITION_FILTER_TOP_ASSERT_SVH

// Implication checked at every rising edge, suspended while rst is high.
`define EFCPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every rising edge, reset included.
`define EFCPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/efcpf_pkg.sv */
// Shared types, constants and CRC tables for the frame check and position filter.
package efcpf_pkg;

   localparam int WORD_W     = 16;
   localparam int POS_W      = 24;
   localparam int WINDOW_W   = 15;
   localparam int LIMIT_W    = 8;
   localparam int ANGLE_W    = 15;
   localparam int REV_W      = 9;
   localparam int MSG_BITS   = 4 * WORD_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0]          CRC_POLY    = 8'h1D;
   localparam logic [7:0]          CRC_INIT    = 8'hFF;
   localparam logic [7:0]          CRC_XOROUT  = 8'hFF;
   localparam logic [WORD_W-1:0]   SAFETY_MASK = 16'h7000;

   localparam logic [WORD_W-1:0]   COMMAND_RESET   = 16'h8023;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 15'd255;
   localparam logic [LIMIT_W-1:0]  TRY_LIMIT_RESET = 8'd255;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COMMAND   = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_TRY_LIMIT = 2'd2
   } csr_addr_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPT = 2'd0,
      STATUS_BAD    = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      logic                    good;
      logic signed [POS_W-1:0] position;
   } frame_info_type;

   typedef logic [MSG_BITS-1:0][7:0] crc_cols_type;

   // Contribution of each message bit to the CRC (bit MSG_BITS-1 goes in first).
   function automatic crc_cols_type crc_columns();
      crc_cols_type cols;
      logic [7:0]   crc;
      logic         fb;
      for (int j = 0; j < MSG_BITS; j++) begin
         crc = '0;
         for (int i = MSG_BITS - 1; i >= 0; i--) begin
            fb  = crc[7] ^ (i == j);
            crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
         end
         cols[j] = crc;
      end
      return cols;
   endfunction

   // CRC of an all-zero message from the init value.
   function automatic logic [7:0] crc_zero_msg();
      logic [7:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < MSG_BITS; i++) begin
         crc = {crc[6:0], 1'b0} ^ (crc[7] ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   localparam crc_cols_type CRC_COLS = crc_columns();
   localparam logic [7:0]   CRC_BASE = crc_zero_msg() ^ CRC_XOROUT;

endpackage

/* rtl/efcpf_frame_check.sv */
// Frame check: safety bits, CRC-8 over command and data words, position decode.
module efcpf_frame_check (
   input  logic [efcpf_pkg::WORD_W-1:0] command_word,
   input  logic [efcpf_pkg::WORD_W-1:0] angle_word,
   input  logic [efcpf_pkg::WORD_W-1:0] speed_word,
   input  logic [efcpf_pkg::WORD_W-1:0] revolution_word,
   input  logic [efcpf_pkg::WORD_W-1:0] safety_word,
   output efcpf_pkg::frame_info_type    info
);
   import efcpf_pkg::*;

   logic [MSG_BITS-1:0] msg;
   logic [7:0]          crc;
   logic                safety_ok;

   assign msg = {command_word, angle_word, speed_word, revolution_word};

   // CRC is linear: xor in the column of every set message bit.
   always_comb begin
      crc = CRC_BASE;
      for (int j = 0; j < MSG_BITS; j++) begin
         crc = crc ^ (msg[j] ? CRC_COLS[j] : 8'h00);
      end
   end

   assign safety_ok = (safety_word & SAFETY_MASK) == SAFETY_MASK;

   assign info.good     = safety_ok && (safety_word[7:0] == crc);
   // signed revolutions in the top bits, angle below: revs * 32768 + angle
   assign info.position = {revolution_word[REV_W-1:0], angle_word[ANGLE_W-1:0]};

endmodule

/* rtl/efcpf_filter.sv */
// Position filter: jump window against last accepted position, with try limit.
module efcpf_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  efcpf_pkg::frame_info_type          info,
   input  logic [efcpf_pkg::WINDOW_W-1:0]     jump_window,
   input  logic [efcpf_pkg::LIMIT_W-1:0]      try_limit,
   output efcpf_pkg::status_type              status,
   output logic signed [efcpf_pkg::POS_W-1:0] position
);
   import efcpf_pkg::*;

   logic signed [POS_W-1:0] last_position_ff;
   logic                    have_reference_ff;
   logic [LIMIT_W-1:0]      reject_count_ff;

   logic signed [POS_W:0]   diff;
   logic signed [POS_W:0]   window;
   logic                    in_window;
   logic [LIMIT_W:0]        count_next;
   logic [LIMIT_W-1:0]      limit;
   logic                    over_limit;
   logic                    accept;

   assign diff   = {info.position[POS_W-1], info.position}
                   - {last_position_ff[POS_W-1], last_position_ff};
   assign window = $signed({{(POS_W + 1 - WINDOW_W){1'b0}}, jump_window});
   assign in_window = (diff <= window) && (diff >= -window);

   // limit of zero behaves as one
   assign limit      = (try_limit == '0) ? LIMIT_W'(1) : try_limit;
   assign count_next = {1'b0, reject_count_ff} + (LIMIT_W + 1)'(1);
   assign over_limit = count_next >= {1'b0, limit};

   assign accept = !have_reference_ff || in_window || over_limit;

   always_comb begin
      if (!info.good) begin
         status   = STATUS_BAD;
         position = '0;
      end else begin
         status   = accept ? STATUS_ACCEPT : STATUS_REJECT;
         position = info.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_position_ff  <= '0;
         have_reference_ff <= 1'b0;
         reject_count_ff   <= '0;
      end else if (step && info.good) begin
         if (accept) begin
            last_position_ff  <= info.position;
            have_reference_ff <= 1'b1;
            reject_count_ff   <= '0;
         end else begin
            reject_count_ff <= count_next[LIMIT_W-1:0];
         end
      end
   end

endmodule

/* rtl/encoder_frame_check_position_filter_top.sv */
// Top level: sensor frame CRC/safety check and position jump filter.
// A request goes from req_ through the input register and the result register to rsp_.
// Throughput: one request per cycle; input register and result register each
// advance whenever the result register is empty or being taken.
// Reset (synchronous, active high): clears both valid stages and the filter
// state, and loads the register defaults (command 0x8023, window 255, limit 255).
module encoder_frame_check_position_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   // request: angle_word [15:0], speed_word [31:16], revolution_word [47:32],
   //          safety_word [63:48]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [efcpf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result: status [1:0], position [25:2], zero [31:26]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [efcpf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register writes: 0 command_word, 1 jump_window, 2 try_limit
   input  logic                                csr_wr_en,
   input  logic [efcpf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [efcpf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import efcpf_pkg::*;

   // configuration registers
   logic [WORD_W-1:0]   command_word_ff;
   logic [WINDOW_W-1:0] jump_window_ff;
   logic [LIMIT_W-1:0]  try_limit_ff;

   // input register stage
   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;

   // result register stage
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic                    rsp_free;
   logic                    advance;
   frame_info_type          info;
   status_type              status;
   logic signed [POS_W-1:0] position;

   // result register can load when empty or drained this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_word_ff <= COMMAND_RESET;
         jump_window_ff  <= WINDOW_RESET;
         try_limit_ff    <= TRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_COMMAND:   command_word_ff <= csr_wdata;
            CSR_WINDOW:    jump_window_ff  <= csr_wdata[WINDOW_W-1:0];
            CSR_TRY_LIMIT: try_limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default:       ; // unmapped index, write dropped
         endcase
      end
   end

   // input stage: payload loads on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   efcpf_frame_check u_frame_check (
      .command_word    (command_word_ff),
      .angle_word      (in_data_ff[15:0]),
      .speed_word      (in_data_ff[31:16]),
      .revolution_word (in_data_ff[47:32]),
      .safety_word     (in_data_ff[63:48]),
      .info            (info)
   );

   // filter state moves in the same cycle the result is registered, so the
   // next request in line already sees it
   efcpf_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .info        (info),
      .jump_window (jump_window_ff),
      .try_limit   (try_limit_ff),
      .status      (status),
      .position    (position)
   );

   assign rsp_data_in = {{(RSP_DATA_W - POS_W - 2){1'b0}}, position, status};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/efcpf_checker.sv */
// Port-level checks for the frame check and position filter, bound to the top level.
`include "encoder_frame_check_position_filter_top_assert.svh"

module efcpf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [efcpf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import efcpf_pkg::*;

   // a stalled result holds
   `EFCPF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // bad frames report position zero
   `EFCPF_ASSERT(a_bad_zero, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == STATUS_BAD) |-> (rsp_tdata[25:2] == '0), "bad frame with nonzero position")

   // padding above the position stays clear
   `EFCPF_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> (rsp_tdata[31:26] == '0), "result padding not zero")

   // reset empties the result stage
   `EFCPF_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "result valid right after reset")

endmodule

bind encoder_frame_check_position_filter_top efcpf_checker u_efcpf_checker (.*);
